### src/mcid_pkg.sv
// Shared constants and types of the multi-channel input debouncer.
package mcid_pkg;

    localparam int CHANNELS     = 8;
    localparam int FIELD_BITS   = 8;
    localparam int TIME_BITS    = 32;
    localparam int MS_BITS      = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int IN_BITS      = TIME_BITS + 2 * FIELD_BITS;
    localparam int OUT_BITS     = 3 * FIELD_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ENABLE       = 3'd0,
        CFG_ACTIVE_HIGH  = 3'd1,
        CFG_LATCH_ENABLE = 3'd2,
        CFG_DEBOUNCE     = 3'd3,
        CFG_SCAN         = 3'd4
    } t_cfg_idx;

    localparam logic [FIELD_BITS-1:0] ENABLE_RESET       = '0;
    localparam logic [FIELD_BITS-1:0] ACTIVE_HIGH_RESET  = '1;
    localparam logic [FIELD_BITS-1:0] LATCH_ENABLE_RESET = '0;
    localparam logic [MS_BITS-1:0]    DEBOUNCE_RESET     = 16'd50;
    localparam logic [MS_BITS-1:0]    SCAN_RESET         = 16'd10;

    // Controls shared by every lane for one word.
    typedef struct packed {
        logic                 fire;
        logic                 first;
        logic                 scan;
        logic [TIME_BITS-1:0] now;
        logic [MS_BITS-1:0]   debounce;
    } t_lane_ctl;

    // Per-lane findings handed to the merging stage.
    typedef struct packed {
        logic [CHANNELS-1:0] level;
        logic [CHANNELS-1:0] changed;
        logic [CHANNELS-1:0] accepted;
    } t_lane_res;

endpackage

### src/mcid_lane.sv
// One debounce lane: level, candidate and edge lockout state of a single channel.
module mcid_lane
    import mcid_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  logic      i_enable,
    input  logic      i_active_high,
    input  logic      i_latch_enable,
    input  logic      i_raw,
    input  logic      i_edge,
    output logic      o_level,
    output logic      o_changed,
    output logic      o_accepted
);

    logic                 r_level, n_level;
    logic                 r_cand, n_cand;
    logic                 r_edge_valid, n_edge_valid;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_edge_time, n_edge_time;

    logic                 w_sample;
    logic                 w_lockout_over;
    logic                 w_stable;
    logic                 w_acc;
    logic [TIME_BITS-1:0] w_edge_age;
    logic [TIME_BITS-1:0] w_cand_age;
    logic [TIME_BITS-1:0] w_debounce;

    assign w_sample       = (i_raw == i_active_high);
    assign w_debounce     = {{(TIME_BITS-MS_BITS){1'b0}}, i_ctl.debounce};
    assign w_edge_age     = i_ctl.now - r_edge_time;
    assign w_cand_age     = i_ctl.now - r_start;
    assign w_lockout_over = !r_edge_valid || (w_edge_age >= w_debounce);
    assign w_stable       = (w_cand_age >= w_debounce);
    assign w_acc          = !i_ctl.first && i_enable && i_latch_enable && i_edge
                            && !r_level && w_lockout_over;

    always_comb begin
        n_level      = r_level;
        n_cand       = r_cand;
        n_start      = r_start;
        n_edge_valid = r_edge_valid;
        n_edge_time  = r_edge_time;
        if (i_ctl.first) begin
            n_level = w_sample;
            n_cand  = w_sample;
            n_start = i_ctl.now;
        end else begin
            if (w_acc) begin
                n_level      = 1'b1;
                n_cand       = 1'b1;
                n_start      = i_ctl.now;
                n_edge_valid = 1'b1;
                n_edge_time  = i_ctl.now;
            end
            if (i_ctl.scan && i_enable) begin
                if (w_sample != n_cand) begin
                    n_cand  = w_sample;
                    n_start = i_ctl.now;
                end else if ((w_sample != n_level) && w_stable) begin
                    n_level = w_sample;
                end
            end
        end
    end

    assign o_level    = n_level;
    assign o_changed  = !i_ctl.first && (n_level != r_level);
    assign o_accepted = w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= 1'b0;
            r_cand       <= 1'b0;
            r_edge_valid <= 1'b0;
        end else if (i_ctl.fire) begin
            r_level      <= n_level;
            r_cand       <= n_cand;
            r_edge_valid <= n_edge_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            r_start     <= n_start;
            r_edge_time <= n_edge_time;
        end
    end

endmodule

### src/mcid_merge.sv
// Merging stage: packs the lane findings into one result word and holds it for the receiver.
module mcid_merge
    import mcid_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  t_lane_res           i_res,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [OUT_BITS-1:0] o_m_tdata,
    output logic                o_free
);

    logic                  r_valid;
    logic [OUT_BITS-1:0]   r_data;
    logic [FIELD_BITS-1:0] w_level, w_changed, w_accepted;

    for (genvar b = 0; b < FIELD_BITS; b++) begin : g_pack
        if (b < CHANNELS) begin : g_used
            assign w_level[b]    = i_res.level[b];
            assign w_changed[b]  = i_res.changed[b];
            assign w_accepted[b] = i_res.accepted[b];
        end else begin : g_unused
            assign w_level[b]    = 1'b0;
            assign w_changed[b]  = 1'b0;
            assign w_accepted[b] = 1'b0;
        end
    end

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_data <= {w_accepted, w_changed, w_level};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

### src/multi_channel_input_debouncer.sv
// Top level of the multi-channel input debouncer: configuration, scan timer, lanes and merge.
//
// Input words arrive on the slave stream: each carries a millisecond timestamp, the raw
// pin level of every channel and the edge flags latched since the previous word. Every
// input word yields exactly one result word on the master stream with the debounced
// levels, the channels whose level changed and the channels activated by a latched edge.
// One lane per channel updates its state in the cycle the word is accepted, so a new word
// can be taken every clock while the output register is empty or being read; the result
// appears from the output register in the cycle after acceptance. The per-lane 32-bit
// time comparisons are all made in the accept cycle. The user must write configuration
// registers through the plain write port only while the block is idle; the block does
// not enforce this. Reset restores the register defaults, empties the output register and
// arms the block so that the first word after reset only loads the levels of all channels.
// When the receiver stalls, the held result stays put and the slave side stops accepting
// until that result is taken; a result taken in the same cycle frees room for a new word.
module multi_channel_input_debouncer
    import mcid_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // Fields from bit 0: time_ms[31:0], raw_levels[39:32], edge_flags[47:40].
    input  logic [IN_BITS-1:0]      i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // Fields from bit 0: debounced_levels[7:0], changed_mask[15:8],
    // edge_accepted_mask[23:16].
    output logic [OUT_BITS-1:0]     o_m_tdata,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [MS_BITS-1:0]      i_cfg_wdata
);

    logic [FIELD_BITS-1:0] r_enable, r_active_high, r_latch_enable;
    logic [MS_BITS-1:0]    r_debounce, r_scan;
    logic [TIME_BITS-1:0]  r_last_scan;
    logic                  r_started;

    logic                  w_fire, w_free, w_scan_hit;
    logic [TIME_BITS-1:0]  w_now, w_scan_age;
    logic [FIELD_BITS-1:0] w_raw, w_edges;
    t_lane_ctl             w_ctl;
    t_lane_res             w_res;

    assign w_now   = i_s_tdata[TIME_BITS-1:0];
    assign w_raw   = i_s_tdata[TIME_BITS +: FIELD_BITS];
    assign w_edges = i_s_tdata[TIME_BITS+FIELD_BITS +: FIELD_BITS];

    assign o_s_tready = w_free;
    assign w_fire     = i_s_tvalid && w_free;

    assign w_scan_age = w_now - r_last_scan;
    assign w_scan_hit = (w_scan_age >= {{(TIME_BITS-MS_BITS){1'b0}}, r_scan});

    assign w_ctl.fire     = w_fire;
    assign w_ctl.first    = !r_started;
    assign w_ctl.scan     = r_started && w_scan_hit;
    assign w_ctl.now      = w_now;
    assign w_ctl.debounce = r_debounce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= ENABLE_RESET;
            r_active_high  <= ACTIVE_HIGH_RESET;
            r_latch_enable <= LATCH_ENABLE_RESET;
            r_debounce     <= DEBOUNCE_RESET;
            r_scan         <= SCAN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:       r_enable       <= i_cfg_wdata[FIELD_BITS-1:0];
                CFG_ACTIVE_HIGH:  r_active_high  <= i_cfg_wdata[FIELD_BITS-1:0];
                CFG_LATCH_ENABLE: r_latch_enable <= i_cfg_wdata[FIELD_BITS-1:0];
                CFG_DEBOUNCE:     r_debounce     <= i_cfg_wdata;
                CFG_SCAN:         r_scan         <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_last_scan <= '0;
        end else if (w_fire) begin
            r_started <= 1'b1;
            if (w_ctl.scan) begin
                r_last_scan <= w_now;
            end
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        logic w_en, w_ah, w_le, w_rw, w_ed;
        if (g < FIELD_BITS) begin : g_wired
            assign w_en = r_enable[g];
            assign w_ah = r_active_high[g];
            assign w_le = r_latch_enable[g];
            assign w_rw = w_raw[g];
            assign w_ed = w_edges[g];
        end else begin : g_idle
            assign w_en = 1'b0;
            assign w_ah = 1'b0;
            assign w_le = 1'b0;
            assign w_rw = 1'b0;
            assign w_ed = 1'b0;
        end
        mcid_lane u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_enable       (w_en),
            .i_active_high  (w_ah),
            .i_latch_enable (w_le),
            .i_raw          (w_rw),
            .i_edge         (w_ed),
            .o_level        (w_res.level[g]),
            .o_changed      (w_res.changed[g]),
            .o_accepted     (w_res.accepted[g])
        );
    end

    mcid_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_res      (w_res),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_free     (w_free)
    );

endmodule

### src/mcid_checker.sv
// Port-level checker of the multi-channel input debouncer and its bind statement.
module mcid_checker
    import mcid_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_s_tvalid,
    input logic                    o_s_tready,
    input logic                    o_m_tvalid,
    input logic                    i_m_tready,
    input logic [OUT_BITS-1:0]     o_m_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result word valid straight after reset.");

    a_word_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("Accepted word produced no result word.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("Input stalled while the output register is empty.");

    a_accepted_is_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[3*FIELD_BITS-1:2*FIELD_BITS]
                         & ~o_m_tdata[FIELD_BITS-1:0]) == '0))
        else $error("Channel activated by an edge is not shown active.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("Stalled result word changed or vanished.");

endmodule

bind multi_channel_input_debouncer mcid_checker u_mcid_checker (.*);

### tb/multi_channel_input_debouncer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-channel input debouncer on its word streams.
module multi_channel_input_debouncer_test;
    import mcid_pkg::*;

    localparam int WORDS_PER_PHASE = 60;
    localparam int PHASES          = 8;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SCRIPT_ROWS     = 30;

    typedef struct packed {
        logic [7:0]  edges;
        logic [7:0]  raw;
        logic [31:0] stamp;
    } t_sample;

    typedef struct packed {
        logic [7:0] accepted;
        logic [7:0] changed;
        logic [7:0] levels;
    } t_outcome;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    reg_idx;
        logic [15:0] value;
        logic [31:0] stamp;
        logic [7:0]  raw;
        logic [7:0]  edges;
        logic        fixed;
        t_outcome    want;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    // Fields from bit 0: time_ms[31:0], raw_levels[39:32], edge_flags[47:40].
    logic [IN_BITS-1:0]      i_s_tdata = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    // Fields from bit 0: debounced_levels[7:0], changed_mask[15:8],
    // edge_accepted_mask[23:16].
    logic [OUT_BITS-1:0]     o_m_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [MS_BITS-1:0]      i_cfg_wdata = '0;

    logic [7:0]  chan_enable   = ENABLE_RESET;
    logic [7:0]  polarity      = ACTIVE_HIGH_RESET;
    logic [7:0]  latch_enable  = LATCH_ENABLE_RESET;
    logic [15:0] debounce_span = DEBOUNCE_RESET;
    logic [15:0] scan_span     = SCAN_RESET;

    logic [7:0]  level_now  = '0;
    logic [7:0]  cand_level = '0;
    logic [7:0]  edge_seen  = '0;
    logic [31:0] cand_since [CHANNELS];
    logic [31:0] edge_at [CHANNELS];
    logic [31:0] last_scan = '0;
    bit          primed = 1'b0;

    t_outcome pending_results [$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       quiet_cycles = 0;

    t_row script [0:SCRIPT_ROWS-1] = '{
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0000, 8'hA5, 8'hFF, 1'b1, 24'h0000A5},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0020, 8'h5A, 8'hFF, 1'b1, 24'h0000A5},
        '{ROW_REG,  CFG_ENABLE,       16'h00FF, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_LATCH_ENABLE, 16'h000F, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_DEBOUNCE,     16'd20,   32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_SCAN,         16'd5,    32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0000, 8'hA5, 8'h5A, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_000A, 8'hA5, 8'h0F, 1'b0, 24'h0},
        '{ROW_REG,  CFG_DEBOUNCE,     16'd0,    32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0010, 8'hA5, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_DEBOUNCE,     16'hFFFF, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0011, 8'hA5, 8'h0A, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'hFFFF_FFF0, 8'hFF, 8'h0A, 1'b0, 24'h0},
        '{ROW_REG,  CFG_SCAN,         16'd0,    32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_DEBOUNCE,     16'd0,    32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0003, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0003, 8'hFF, 8'hFF, 1'b0, 24'h0},
        '{ROW_REG,  CFG_ACTIVE_HIGH,  16'h0000, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_ENABLE,       16'h000F, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0004, 8'h00, 8'hFF, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0000_0005, 8'hFF, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_LATCH_ENABLE, 16'h00FF, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_ENABLE,       16'h00FF, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_DEBOUNCE,     16'hFFFF, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_REG,  CFG_SCAN,         16'hFFFF, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'hFFFF_FFFF, 8'h00, 8'hFF, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0001_0000, 8'h55, 8'hAA, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0002_0000, 8'hAA, 8'h55, 1'b0, 24'h0},
        '{ROW_REG,  CFG_ACTIVE_HIGH,  16'h00F0, 32'h0, 8'h00, 8'h00, 1'b0, 24'h0},
        '{ROW_WORD, CFG_ENABLE,       16'h0000, 32'h0003_0000, 8'h0F, 8'hF0, 1'b0, 24'h0}
    };

    multi_channel_input_debouncer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit take_gap();
        if ((cycle_count % 700) < 200) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 11;
    endfunction

    function automatic bit span_over(input logic [31:0] now, input logic [31:0] since,
                                     input logic [15:0] span);
        logic [31:0] gap_ms;
        gap_ms = now - since;
        return gap_ms >= {16'd0, span};
    endfunction

    function automatic t_outcome debounce_step(input t_sample w);
        t_outcome   r;
        logic [7:0] prior;
        logic [7:0] sensed;
        r = '0;
        sensed = ~(w.raw ^ polarity);
        if (!primed) begin
            level_now = sensed;
            cand_level = sensed;
            for (int i = 0; i < CHANNELS; i++) begin
                cand_since[i] = w.stamp;
            end
            primed = 1'b1;
            r.levels = level_now;
            return r;
        end
        prior = level_now;
        for (int i = 0; i < CHANNELS; i++) begin
            if (chan_enable[i] && latch_enable[i] && w.edges[i] && !level_now[i] &&
                (!edge_seen[i] || span_over(w.stamp, edge_at[i], debounce_span))) begin
                edge_at[i] = w.stamp;
                edge_seen[i] = 1'b1;
                level_now[i] = 1'b1;
                cand_level[i] = 1'b1;
                cand_since[i] = w.stamp;
                r.accepted[i] = 1'b1;
            end
        end
        if (span_over(w.stamp, last_scan, scan_span)) begin
            last_scan = w.stamp;
            for (int i = 0; i < CHANNELS; i++) begin
                if (chan_enable[i]) begin
                    if (sensed[i] != cand_level[i]) begin
                        cand_level[i] = sensed[i];
                        cand_since[i] = w.stamp;
                    end else if (sensed[i] != level_now[i] &&
                                 span_over(w.stamp, cand_since[i], debounce_span)) begin
                        level_now[i] = sensed[i];
                    end
                end
            end
        end
        r.levels = level_now;
        r.changed = level_now ^ prior;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: %s mismatch, got %h, expected %h", $time, field, got, want);
        error_count++;
    endtask

    task automatic send_word(input t_sample w, input bit fixed, input t_outcome want);
        t_outcome predicted;
        while (take_gap()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= w;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        predicted = debounce_step(w);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            CFG_ENABLE:       chan_enable = value[7:0];
            CFG_ACTIVE_HIGH:  polarity = value[7:0];
            CFG_LATCH_ENABLE: latch_enable = value[7:0];
            CFG_DEBOUNCE:     debounce_span = value;
            CFG_SCAN:         scan_span = value;
            default:          ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        cycle_count <= cycle_count + 1;
        i_m_tready <= !take_gap();
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_outcome'(o_m_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, debounced_levels", got.levels, 8'h00);
            end else begin
                want = pending_results.pop_front();
                if (got.levels !== want.levels) begin
                    report_mismatch("debounced_levels", got.levels, want.levels);
                end
                if (got.changed !== want.changed) begin
                    report_mismatch("changed_mask", got.changed, want.changed);
                end
                if (got.accepted !== want.accepted) begin
                    report_mismatch("edge_accepted_mask", got.accepted, want.accepted);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_sample     w;
        logic [31:0] clock_ms;
        logic [7:0]  pins;
        logic [7:0]  en_v;
        logic [7:0]  ah_v;
        logic [7:0]  le_v;
        logic [15:0] db_v;
        logic [15:0] scan_v;
        int          step_max;
        for (int i = 0; i < CHANNELS; i++) begin
            cand_since[i] = '0;
            edge_at[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            if (script[r].kind == ROW_REG) begin
                write_reg(script[r].reg_idx, script[r].value);
            end else begin
                w.stamp = script[r].stamp;
                w.raw = script[r].raw;
                w.edges = script[r].edges;
                send_word(w, script[r].fixed, script[r].want);
            end
        end

        clock_ms = 32'h0004_0000;
        pins = 8'h00;
        for (int ph = 0; ph < PHASES; ph++) begin
            en_v = 8'hFF;
            ah_v = 8'($urandom_range(0, 255));
            le_v = 8'($urandom_range(0, 255));
            db_v = 16'($urandom_range(1, 30));
            scan_v = 16'($urandom_range(0, 10));
            step_max = 12;
            case (ph)
                0: begin
                    ah_v = 8'hFF;
                    le_v = 8'h00;
                end
                1: begin
                    ah_v = 8'h00;
                    le_v = 8'hFF;
                end
                2: en_v = 8'($urandom_range(0, 255));
                3: begin
                    le_v = 8'hFF;
                    db_v = 16'd0;
                    scan_v = 16'd0;
                end
                4: clock_ms = 32'hFFFF_FF80;
                5: begin
                    ah_v = 8'hFF;
                    le_v = 8'hFF;
                    db_v = 16'hFFFF;
                    scan_v = 16'hFFFF;
                    step_max = 90000;
                end
                6: begin
                    en_v = 8'($urandom_range(0, 255));
                    db_v = 16'($urandom_range(0, 65535));
                    scan_v = 16'($urandom_range(0, 65535));
                    step_max = 90000;
                end
                default: ;
            endcase
            write_reg(CFG_ENABLE, {8'h00, en_v});
            write_reg(CFG_ACTIVE_HIGH, {8'h00, ah_v});
            write_reg(CFG_LATCH_ENABLE, {8'h00, le_v});
            write_reg(CFG_DEBOUNCE, db_v);
            write_reg(CFG_SCAN, scan_v);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    clock_ms = $urandom;
                    pins = 8'($urandom);
                    w.edges = 8'($urandom);
                end else begin
                    clock_ms = clock_ms + 32'($urandom_range(0, step_max));
                    pins = pins ^ 8'($urandom & $urandom & $urandom);
                    w.edges = 8'($urandom & $urandom & $urandom);
                end
                w.stamp = clock_ms;
                w.raw = pins;
                send_word(w, 1'b0, '0);
            end
        end

        settle();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
